// ===== src/pcp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types and constants for the pair correlator product block.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'hFFF8_0000_0000_0000;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef enum logic [2:0] {
    C_CLEAR,
    C_IDLE,
    C_SCAN,
    C_READ,
    C_MUL,
    C_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    FM_IDLE,
    FM_PP,
    FM_NORM,
    FM_ROUND,
    FM_DONE
  } fmul_state_t;

  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic eval_load;
    logic scan_adv;
    logic rd_en;
    logic mul_start;
    logic out_load;
  } pcp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pair_occ;
    logic pair_last;
    logic mul_done;
    logic out_full;
  } pcp_status_t;

endpackage

// ===== src/pcp_fmul.sv =====
// ----------------------------------------------------------------------------
// pcp_fmul
// Sequential IEEE double multiplier, round to nearest even. Four 27x27
// partial products, then one-bit-per-cycle normalisation, then rounding.
// ----------------------------------------------------------------------------
module pcp_fmul
  import pcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  fmul_state_t        state_r, state_nxt;
  logic [52:0]        ma_r;
  logic [52:0]        mb_r;
  logic               sign_r;
  logic signed [12:0] e_r;
  logic [105:0]       sum_r;
  logic [53:0]        pp_r;
  logic [1:0]         pk_r;
  logic [2:0]         cnt_r;
  logic [63:0]        res_r;

  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
  logic [10:0] eae, ebe;
  logic [26:0] opx, opy;
  logic [6:0]  shamt;
  logic [53:0] mr;
  logic        inc;
  logic [52:0] mant;
  logic signed [12:0] er;

  assign ea     = a[62:52];
  assign eb     = b[62:52];
  assign fa     = a[51:0];
  assign fb     = b[51:0];
  assign nan_a  = (ea == 11'h7FF) && (fa != '0);
  assign nan_b  = (eb == 11'h7FF) && (fb != '0);
  assign inf_a  = (ea == 11'h7FF) && (fa == '0);
  assign inf_b  = (eb == 11'h7FF) && (fb == '0);
  assign zero_a = (ea == '0) && (fa == '0);
  assign zero_b = (eb == '0) && (fb == '0);
  assign sgn    = a[63] ^ b[63];
  assign eae    = (ea == '0) ? 11'd1 : ea;
  assign ebe    = (eb == '0) ? 11'd1 : eb;

  assign opx = cnt_r[1] ? {1'b0, ma_r[52:27]} : ma_r[26:0];
  assign opy = cnt_r[0] ? {1'b0, mb_r[52:27]} : mb_r[26:0];

  always_comb begin
    unique case (pk_r)
      2'd0:    shamt = 7'd0;
      2'd3:    shamt = 7'd54;
      default: shamt = 7'd27;
    endcase
  end

  assign inc  = sum_r[52] & ((|sum_r[51:0]) | sum_r[53]);
  assign mr   = {1'b0, sum_r[105:53]} + 54'(inc);
  assign mant = mr[53] ? mr[53:1] : mr[52:0];
  assign er   = mr[53] ? (e_r + 13'sd1) : e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FM_IDLE:  if (start) begin
                  if (nan_a || nan_b || inf_a || inf_b || zero_a || zero_b) begin
                    state_nxt = FM_DONE;
                  end else begin
                    state_nxt = FM_PP;
                  end
                end
      FM_PP:    if (cnt_r == 3'd4) state_nxt = FM_NORM;
      FM_NORM:  if (e_r >= 13'sd1 && (sum_r[105] || e_r == 13'sd1)) state_nxt = FM_ROUND;
      FM_ROUND: state_nxt = FM_DONE;
      FM_DONE:  state_nxt = FM_IDLE;
      default:  state_nxt = FM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      FM_IDLE: begin
        ma_r   <= {ea != '0, fa};
        mb_r   <= {eb != '0, fb};
        sign_r <= sgn;
        e_r    <= $signed({2'b00, eae}) + $signed({2'b00, ebe}) - 13'sd1022;
        sum_r  <= '0;
        cnt_r  <= '0;
        if (nan_a) begin
          res_r <= a | 64'h0008_0000_0000_0000;
        end else if (nan_b) begin
          res_r <= b | 64'h0008_0000_0000_0000;
        end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
          res_r <= QNAN_BITS;
        end else if (inf_a || inf_b) begin
          res_r <= {sgn, 11'h7FF, 52'b0};
        end else begin
          res_r <= {sgn, 63'b0};
        end
      end
      FM_PP: begin
        if (cnt_r != 3'd4) begin
          pp_r <= opx * opy;
          pk_r <= cnt_r[1:0];
        end
        if (cnt_r != 3'd0) begin
          sum_r <= sum_r + (106'(pp_r) << shamt);
        end
        cnt_r <= cnt_r + 3'd1;
      end
      FM_NORM: begin
        if (e_r < 13'sd1) begin
          // underflow: denormalise, fold dropped bits into the sticky bit
          if (e_r < -13'sd110) begin
            sum_r <= {105'b0, |sum_r};
            e_r   <= 13'sd1;
          end else begin
            sum_r <= {1'b0, sum_r[105:2], sum_r[1] | sum_r[0]};
            e_r   <= e_r + 13'sd1;
          end
        end else if (!sum_r[105] && e_r > 13'sd1) begin
          sum_r <= {sum_r[104:0], 1'b0};
          e_r   <= e_r - 13'sd1;
        end
      end
      FM_ROUND: begin
        if (er >= 13'sd2047) begin
          res_r <= {sign_r, 11'h7FF, 52'b0};
        end else begin
          res_r <= {sign_r, mant[52] ? er[10:0] : 11'd0, mant[51:0]};
        end
      end
      default: ;
    endcase
  end

  assign done = (state_r == FM_DONE);
  assign res  = res_r;

endmodule

// ===== src/pcp_datapath.sv =====
// ----------------------------------------------------------------------------
// pcp_datapath
// Correlator table memory, pair scan counters, product accumulator and
// result register.
// ----------------------------------------------------------------------------
module pcp_datapath
  import pcp_pkg::*;
#(
  parameter int SPATIAL_ORBITALS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pcp_cmd_t    cmd,
  output pcp_status_t status,
  input  logic [9:0]  in_entry_index,
  input  logic [63:0] in_entry_value,
  input  logic [31:0] in_occupancy,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [63:0] out_product
);

  localparam int SPIN  = 2 * SPATIAL_ORBITALS;
  localparam int DEPTH = SPIN * (SPIN + 1) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SPIN);

  logic [63:0]     mem [DEPTH];
  logic [63:0]     rdata_r;
  logic [AW-1:0]   clr_r;
  logic [SW-1:0]   hi_r, lo_r;
  logic [AW-1:0]   idx_r;
  logic [SPIN-1:0] occ_r;
  logic [63:0]     acc_r;
  logic            out_valid_r;
  logic [63:0]     out_product_r;

  logic            wr_ok;
  logic            mul_done;
  logic [63:0]     mul_res;

  assign wr_ok = cmd.wr_en && (32'(in_entry_index) < DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_r] <= ONE_BITS;
    end else if (wr_ok) begin
      mem[AW'(in_entry_index)] <= in_entry_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_r <= clr_r + AW'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_load) begin
      occ_r <= SPIN'(in_occupancy);
      hi_r  <= '0;
      lo_r  <= '0;
      idx_r <= '0;
      acc_r <= ONE_BITS;
    end else begin
      if (cmd.scan_adv) begin
        if (lo_r == hi_r) begin
          hi_r <= hi_r + SW'(1);
          lo_r <= '0;
        end else begin
          lo_r <= lo_r + SW'(1);
        end
        idx_r <= idx_r + AW'(1);
      end
      if (mul_done) acc_r <= mul_res;
    end
    if (cmd.out_load) out_product_r <= acc_r;
  end

  pcp_fmul u_fmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (acc_r),
    .b     (rdata_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign status.clr_last  = (clr_r == AW'(DEPTH - 1));
  assign status.pair_occ  = occ_r[hi_r] & occ_r[lo_r];
  assign status.pair_last = (hi_r == SW'(SPIN - 1)) && (lo_r == hi_r);
  assign status.mul_done  = mul_done;
  assign status.out_full  = out_valid_r & out_stall;

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;

endmodule

// ===== src/pcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcp_ctrl
// Controller: table clearing after reset, request intake, pair scan and
// multiply sequencing.
// ----------------------------------------------------------------------------
module pcp_ctrl
  import pcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_func,
  output logic        in_stall,
  input  pcp_status_t status,
  output pcp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      C_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) state_nxt = C_IDLE;
      end
      C_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.eval_load = 1'b1;
            state_nxt     = C_SCAN;
          end
        end
      end
      C_SCAN: begin
        if (status.pair_occ) begin
          cmd.rd_en = 1'b1;
          state_nxt = C_READ;
        end else if (status.pair_last) begin
          state_nxt = C_FINISH;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      C_READ: begin
        cmd.mul_start = 1'b1;
        state_nxt     = C_MUL;
      end
      C_MUL: begin
        if (status.mul_done) begin
          if (status.pair_last) begin
            state_nxt = C_FINISH;
          end else begin
            cmd.scan_adv = 1'b1;
            state_nxt    = C_SCAN;
          end
        end
      end
      C_FINISH: begin
        // hold until the result register can take the product
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

endmodule

// ===== src/pair_correlator_product.sv =====
// ----------------------------------------------------------------------------
// pair_correlator_product
// Packed lower-triangular table of double correlators; a write request
// stores an entry, an evaluate request returns the product over all
// occupied orbital pairs.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_func, in_entry_index,
//           |           | in_entry_value, in_occupancy
//   out     | output    | out_valid, out_stall, out_product
//
// A write is stored while the block stays idle, ready for the next request.
// An evaluate scans every pair in turn (2S(2S+1)/2 for S spatial orbitals),
// runs the sequential double multiplier for each occupied pair, then loads
// the result. The multiplier skips its partial products when an operand is
// zero, infinite or NaN, and shifts further when a subnormal needs
// normalising or the product underflows. After reset the table is cleared
// to 1.0, one entry a cycle, with in_stall high. A stalled result is held in
// the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module pair_correlator_product
  import pcp_pkg::*;
#(
  parameter int SPATIAL_ORBITALS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [9:0]  in_entry_index,
  input  logic [63:0] in_entry_value,
  input  logic [31:0] in_occupancy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_product
);

  pcp_cmd_t    cmd;
  pcp_status_t status;

  pcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcp_datapath #(
    .SPATIAL_ORBITALS (SPATIAL_ORBITALS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_occupancy   (in_occupancy),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_product    (out_product)
  );

endmodule

// ===== sim/tb_pair_correlator_product.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pair_correlator_product
// Self-checking bench for the pair correlator product block. Table writes
// and evaluate requests are driven with random gaps. A local copy of the
// correlator table predicts every product in double precision, and each
// returned product is checked against the oldest prediction. A NaN matches
// any NaN. Phases cover directed corner values, a random mix, back-to-back
// traffic and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_pair_correlator_product;
  import pcp_pkg::*;

  localparam int SPATIAL   = 16;
  localparam int SPIN      = 2 * SPATIAL;
  localparam int DEPTH     = SPIN * (SPIN + 1) / 2;
  localparam int CYC_LIMIT = 30_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = FUNC_WRITE;
  logic [9:0]  in_entry_index = '0;
  logic [63:0] in_entry_value = '0;
  logic [31:0] in_occupancy = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_product;

  logic [63:0] corr_table [DEPTH];
  logic [63:0] product_q [$];

  int tx_gap_max = 10;
  int rx_gap_max = 10;
  int rx_wait = 0;
  int hold_cycles = 0;
  int cyc = 0;
  int errors = 0;
  int n_writes = 0;
  int n_evals = 0;
  int n_results = 0;

  pair_correlator_product #(.SPATIAL_ORBITALS(SPATIAL)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_entry_index(in_entry_index), .in_entry_value(in_entry_value),
    .in_occupancy(in_occupancy),
    .out_valid(out_valid), .out_stall(out_stall), .out_product(out_product)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("%0t: timeout with %0d products outstanding", $time, product_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic is_nan(input logic [63:0] b);
    return (&b[62:52]) && (|b[51:0]);
  endfunction

  // Multiply every occupied pair in order, lower orbital innermost.
  function automatic logic [63:0] predict_product(input logic [31:0] occ);
    real acc;
    acc = 1.0;
    for (int hi = 0; hi < SPIN; hi++) begin
      if (occ[hi]) begin
        for (int lo = 0; lo <= hi; lo++) begin
          if (occ[lo]) acc = acc * $bitstoreal(corr_table[hi * (hi + 1) / 2 + lo]);
        end
      end
    end
    return $realtobits(acc);
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: v[62:0] = '0;
      1: v[62:0] = {11'h7FF, 52'h0};
      2: begin
        v[62:52] = 11'h7FF;
        if (v[51:0] == '0) v[0] = 1'b1;
      end
      3: v[62:52] = 11'h000;
      4: v[62:52] = 11'($urandom_range(0, 2046));
      default: v[62:52] = $urandom_range(0, 1) ? 11'h3FF : 11'h3FE;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_occ();
    logic [31:0] o;
    int k;
    o = '0;
    case ($urandom_range(0, 19))
      0: o = '0;
      1, 2: o = $urandom;
      default: begin
        k = $urandom_range(1, 6);
        repeat (k) o[$urandom_range(0, SPIN - 1)] = 1'b1;
      end
    endcase
    return o;
  endfunction

  function automatic logic [9:0] rand_index();
    int row;
    if ($urandom_range(0, 6) == 0) return 10'($urandom_range(0, 1023));
    row = $urandom_range(0, SPIN - 1);
    return 10'(row * (row + 1) / 2 + $urandom_range(0, row));
  endfunction

  task automatic send_request(input logic func, input logic [9:0] idx,
                              input logic [63:0] val, input logic [31:0] occ);
    int gap;
    gap = tx_gap_max > 0 ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= func;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_occupancy <= occ;
    do @(posedge clk); while (in_stall);
    if (func == FUNC_WRITE) begin
      if (idx < DEPTH) corr_table[idx] = val;
      n_writes++;
    end else begin
      product_q.push_back(predict_product(occ));
      n_evals++;
    end
  endtask

  task automatic send_write(input logic [9:0] idx, input logic [63:0] val);
    send_request(FUNC_WRITE, idx, val, $urandom);
  endtask

  task automatic send_eval(input logic [31:0] occ);
    send_request(FUNC_EVAL, 10'($urandom), {$urandom, $urandom}, occ);
  endtask

  task automatic send_random();
    if ($urandom_range(0, 1)) send_write(rand_index(), rand_double());
    else send_eval(rand_occ());
  endtask

  task automatic wait_drain();
    // drop valid so the last request is not taken twice
    @(negedge clk);
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Receiver: hold off for the long stretch first, then per-result gaps.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    logic [63:0] want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (product_q.size() == 0) begin
        $display("%0t: unexpected product %h", $time, out_product);
        errors++;
      end else begin
        want = product_q.pop_front();
        if (is_nan(want) ? !is_nan(out_product) : (want !== out_product)) begin
          $display("%0t: product mismatch expected %h actual %h", $time, want, out_product);
          errors++;
        end
      end
      rx_wait <= rx_gap_max > 0 ? $urandom_range(0, rx_gap_max) : 0;
    end
  end

  task automatic test_reset_table();
    send_eval('0);
    send_eval(32'hFFFF_FFFF);
    send_eval(32'h8000_0001);
    wait_drain();
  endtask

  task automatic test_directed_values();
    send_write(10'd0, 64'h4000_0000_0000_0000);        // 2.0 at (0,0)
    send_write(10'd527, 64'h7FEF_FFFF_FFFF_FFFF);      // largest finite at (31,31)
    send_write(10'd528, 64'h0000_0000_0000_0000);      // out of range, drop
    send_write(10'd1023, 64'hFFFF_FFFF_FFFF_FFFF);     // out of range, drop
    send_eval(32'h0000_0001);
    send_eval(32'h8000_0000);
    send_eval(32'h8000_0001);
    send_write(10'd1, 64'h0000_0000_0000_0001);        // smallest subnormal at (1,0)
    send_eval(32'h0000_0003);
    send_write(10'd2, 64'h8000_0000_0000_0000);        // negative zero at (1,1)
    send_eval(32'h0000_0003);
    send_write(10'd3, 64'h7FF0_0000_0000_0000);        // infinity at (2,0)
    send_eval(32'h0000_0005);
    send_eval(32'h0000_0007);                          // infinity times zero
    send_write(10'd5, 64'h7FF8_0000_0000_1234);        // NaN at (2,2)
    send_eval(32'h0000_0004);
    send_write(10'd3, 64'hBFF0_0000_0000_0000);
    send_write(10'd2, 64'h3FF0_0000_0000_0000);
    send_write(10'd1, 64'h3FF0_0000_0000_0000);
    send_write(10'd5, 64'h3FF0_0000_0000_0000);
    send_eval(32'hFFFF_FFFF);
    wait_drain();
  endtask

  task automatic test_random_mix(input int count);
    tx_gap_max = 10;
    rx_gap_max = 10;
    repeat (count) send_random();
    wait_drain();
  endtask

  task automatic test_back_to_back(input int count);
    tx_gap_max = 0;
    rx_gap_max = 0;
    repeat (count) send_random();
    wait_drain();
  endtask

  task automatic test_output_hold();
    tx_gap_max = 0;
    rx_gap_max = 3;
    hold_cycles = 4000;
    repeat (30) send_eval(rand_occ());
    wait_drain();
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) corr_table[k] = ONE_BITS;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_table();
    test_directed_values();
    test_random_mix(600);
    test_back_to_back(200);
    test_output_hold();
    test_random_mix(200);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (100) @(posedge clk);
    $display("Covered %0d table writes and %0d evaluations, %0d products checked.",
             n_writes, n_evals, n_results);
    $display("Included corner values, full occupancy, back-to-back and held output.");
    if (errors == 0 && product_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
